/* sv/mm4_pkg.sv */
// mm4_pkg: shared types and constants for the 4x4 fixed-point matrix multiply
// no dependencies
package mm4_pkg;
	localparam int DIM_DEF = 4;
	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS = 16;

	typedef struct packed {
		logic [3:0] position;
		logic signed [31:0] a_element;
		logic signed [31:0] b_element;
		logic last;
	} mm4_in_t;

	typedef struct packed {
		logic [1:0] out_row;
		logic [1:0] out_column;
		logic signed [31:0] product_value;
		logic saturated;
		logic final_result;
	} mm4_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_EMIT
	} mm4_state_t;

	typedef struct packed {
		logic clear;
		logic acc_en;
	} mm4_mac_ctl_t;
endpackage

/* sv/mm4_mac_cell.sv */
// mm4_mac_cell: one multiply-accumulate cell of the product chain
// depends on mm4_pkg
module mm4_mac_cell import mm4_pkg::*; #(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	parameter int ACC_WIDTH = 2 * ELEM_WIDTH + 3
) (
	input  logic clk,
	input  logic arst_n,
	input  mm4_mac_ctl_t ctl,
	input  logic signed [ELEM_WIDTH-1:0] a,
	input  logic signed [ELEM_WIDTH-1:0] b,
	input  logic signed [ELEM_WIDTH-1:0] b_in,
	output logic signed [ELEM_WIDTH-1:0] b_out,
	output logic signed [ACC_WIDTH-1:0] acc
);
	logic signed [2*ELEM_WIDTH-1:0] prod_s1;
	logic signed [ACC_WIDTH-1:0] acc_q;
	logic signed [ELEM_WIDTH-1:0] b_q;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		b_q <= b_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + ACC_WIDTH'(prod_s1);
		end
	end

	assign b_out = b_q;
	assign acc = acc_q;
endmodule

/* sv/mm4_sat.sv */
// mm4_sat: shift, saturate and sign-extend an accumulated dot product
// depends on mm4_pkg
module mm4_sat import mm4_pkg::*; #(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	parameter int ACC_WIDTH = 2 * ELEM_WIDTH + 3
) (
	input  logic signed [ACC_WIDTH-1:0] acc,
	output logic signed [31:0] value,
	output logic sat
);
	localparam int SH_WIDTH = ACC_WIDTH - FRAC_BITS;
	logic signed [SH_WIDTH-1:0] sh;
	logic signed [SH_WIDTH-1:0] maxv;
	logic signed [SH_WIDTH-1:0] minv;
	logic signed [ELEM_WIDTH-1:0] v;

	assign sh = SH_WIDTH'(acc >>> FRAC_BITS);
	assign maxv = SH_WIDTH'((64'sd1 <<< (ELEM_WIDTH - 1)) - 64'sd1);
	assign minv = -maxv - SH_WIDTH'(1);

	always_comb begin
		sat = 1'b0;
		v = ELEM_WIDTH'(sh);
		if (sh > maxv) begin
			v = ELEM_WIDTH'(maxv);
			sat = 1'b1;
		end else if (sh < minv) begin
			v = ELEM_WIDTH'(minv);
			sat = 1'b1;
		end
	end

	assign value = 32'(v);
endmodule

/* sv/matrix_multiply_4x4_unit.sv */
// matrix_multiply_4x4_unit: top level, element stores, sequencer and a chain of mac cells
// depends on mm4_pkg, mm4_mac_cell, mm4_sat
//
// channel  | handshake      | payload
// in       | start / busy   | in_data (mm4_in_t)
// out      | result_valid   | result (mm4_out_t)
//
// a load is accepted while busy is low; a last item then holds busy for DIM
// rows: one row of DIM cells takes a k-step per cycle, an accumulate state
// adds the last registered product, and DIM results then leave one per
// cycle. results cannot be stalled. reset clears both stores to zero.
module matrix_multiply_4x4_unit import mm4_pkg::*; #(
	parameter int DIM = DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  mm4_in_t in_data,
	output logic busy,
	output logic result_valid,
	output mm4_out_t result
);
	localparam int CELLS = DIM * DIM;
	localparam int IW = $clog2(CELLS);
	localparam int DW = $clog2(DIM);
	localparam int ACC_WIDTH = 2 * ELEM_WIDTH + 3;

	logic signed [ELEM_WIDTH-1:0] left_q [CELLS];
	logic signed [ELEM_WIDTH-1:0] right_q [CELLS];
	mm4_state_t state_q, state_d;
	logic [DW-1:0] row_q, k_q, col_q;
	logic [DW:0] cnt_q;
	logic accept;
	mm4_mac_ctl_t ctl;
	logic signed [ELEM_WIDTH-1:0] b_chain [DIM+1];
	logic signed [ACC_WIDTH-1:0] acc [DIM];
	logic signed [31:0] sat_val;
	logic sat_flag;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				left_q[i] <= '0;
				right_q[i] <= '0;
			end
		end else if (accept && 32'(in_data.position) < CELLS) begin
			left_q[IW'(in_data.position)] <= ELEM_WIDTH'(in_data.a_element);
			right_q[IW'(in_data.position)] <= ELEM_WIDTH'(in_data.b_element);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && in_data.last) state_d = ST_MUL;
			ST_MUL: if (32'(cnt_q) == DIM - 1) state_d = ST_ACC;
			ST_ACC: state_d = ST_EMIT;
			ST_EMIT: begin
				if (32'(col_q) == DIM - 1)
					state_d = (32'(row_q) == DIM - 1) ? ST_IDLE : ST_MUL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		ctl.clear = (state_q == ST_IDLE) || (state_q == ST_MUL && cnt_q == '0);
		ctl.acc_en = (state_q == ST_ACC) || (state_q == ST_MUL && cnt_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			k_q <= '0;
			col_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					k_q <= '0;
					col_q <= '0;
					cnt_q <= '0;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					k_q <= k_q + 1'b1;
				end
				ST_ACC: begin
					cnt_q <= '0;
					k_q <= '0;
					col_q <= '0;
				end
				ST_EMIT: begin
					col_q <= col_q + 1'b1;
					if (32'(col_q) == DIM - 1) row_q <= row_q + 1'b1;
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	// a is broadcast per k-step; each cell reads its own column of b
	assign b_chain[0] = '0;
	for (genvar c = 0; c < DIM; c++) begin : g_cell
		mm4_mac_cell #(.ELEM_WIDTH(ELEM_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.a(left_q[IW'(32'(row_q) * DIM + 32'(k_q))]),
			.b(right_q[IW'(32'(k_q) * DIM + c)]),
			.b_in(b_chain[c]),
			.b_out(b_chain[c+1]),
			.acc(acc[c])
		);
	end

	mm4_sat #(.ELEM_WIDTH(ELEM_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_sat (
		.acc(acc[col_q]),
		.value(sat_val),
		.sat(sat_flag)
	);

	always_comb begin
		result_valid = (state_q == ST_EMIT);
		result.out_row = 2'(row_q);
		result.out_column = 2'(col_q);
		result.product_value = sat_val;
		result.saturated = sat_flag;
		result.final_result = (32'(row_q) == DIM - 1) && (32'(col_q) == DIM - 1);
	end
endmodule

/* sv/mm4_checker.sv */
// mm4_checker: port-level assertions for matrix_multiply_4x4_unit, bound to the top level
// depends on mm4_pkg
module mm4_checker import mm4_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid,
	input mm4_out_t result
);
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result without busy");
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.final_result |=> !busy) else $error("busy after final transfer");
	a_final_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.final_result |-> result.out_row == 2'd3 && result.out_column == 2'd3)
		else $error("final transfer at wrong position");
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.out_column != 2'd3 |=> result_valid)
		else $error("row of transfers broken");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !busy) else $error("busy without a transfer");
endmodule

bind matrix_multiply_4x4_unit mm4_checker u_mm4_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid), .result(result)
);
